### hdl/iaw_pkg.sv
// Shared types and constants for the im2col address walker.
// Holds the register file layout, its reset image and the per-item flags.
// No dependencies.
package iaw_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIZE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DILATION = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD      = 3'd7;

  typedef struct packed {
    logic        layout;
    logic [15:0] channels;
    logic [23:0] kernel_size;
    logic [47:0] in_size;
    logic [47:0] out_size;
    logic [23:0] stride_size;
    logic [23:0] dilation_size;
    logic [23:0] pad_before;
  } iaw_cfg_t;

  localparam iaw_cfg_t CFG_RESET = '{
    layout:        1'b0,
    channels:      16'd1,
    kernel_size:   24'h010101,
    in_size:       48'h0001_0001_0001,
    out_size:      48'h0001_0001_0001,
    stride_size:   24'h010101,
    dilation_size: 24'h010101,
    pad_before:    24'h000000
  };

  typedef struct packed {
    logic pad;
    logic last;
  } iaw_flags_t;

endpackage

### hdl/im2col_address_walker.sv
// Top level of the 3D im2col address walker: register file, walk front end,
// item queue and address back end. Uses iaw_pkg, iaw_front, iaw_fifo, iaw_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one item per cycle: a restart
//   flag and the image base. Each item yields exactly one result item on the
//   output channel (out_valid_o/out_ready_i): source address, pad flag,
//   column buffer index and last flag, in walk order.
//   Configuration port (cfg_valid_i/cfg_ready_o) writes register
//   cfg_index_i with cfg_data_i; it is always ready. Write only while idle.
//   Path from input accept to output valid: the queue write, then the four
//   multiply stages and the output register of the back end.
//   Throughput: one item per cycle while the queue is not full, held by the front
//   end's counter update on every accept and the fully pipelined back end.
//   Stall: a held output freezes the back end; the 4-entry queue keeps
//   taking items, and in_ready_o drops only once the queue is full.
//   Reset: walk counters clear to zero, registers take their reset values,
//   queue and pipeline empty. No clearing pass.
module im2col_address_walker #(
  parameter int ADDR_WIDTH = 32,
  parameter int DIM_WIDTH  = 16,
  parameter int KERN_WIDTH = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [iaw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [iaw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            restart_i,
  input  logic [31:0]                     image_base_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [31:0]                     src_addr_o,
  output logic                            pad_o,
  output logic [31:0]                     col_index_o,
  output logic                            last_o
);

  localparam int Q_DEPTH = 4;
  localparam int Q_W     = 32 + 32 + $bits(iaw_pkg::iaw_flags_t) + 16 + 3 * DIM_WIDTH;

  iaw_pkg::iaw_cfg_t cfg_q, cfg_d;

  logic                   accept;
  logic                   q_full, q_valid, q_pop;
  logic [Q_W-1:0]         q_wdata, q_rdata;

  logic [15:0]            f_chan, b_chan;
  logic [DIM_WIDTH-1:0]   f_d, f_h, f_w, b_d, b_h, b_w;
  iaw_pkg::iaw_flags_t    f_flags, b_flags;
  logic [31:0]            f_col, b_col, b_base;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        iaw_pkg::CFG_LAYOUT:   cfg_d.layout        = cfg_data_i[0];
        iaw_pkg::CFG_CHANNELS: cfg_d.channels      = cfg_data_i[15:0];
        iaw_pkg::CFG_KERNEL:   cfg_d.kernel_size   = cfg_data_i[23:0];
        iaw_pkg::CFG_IN_SIZE:  cfg_d.in_size       = cfg_data_i[47:0];
        iaw_pkg::CFG_OUT_SIZE: cfg_d.out_size      = cfg_data_i[47:0];
        iaw_pkg::CFG_STRIDE:   cfg_d.stride_size   = cfg_data_i[23:0];
        iaw_pkg::CFG_DILATION: cfg_d.dilation_size = cfg_data_i[23:0];
        iaw_pkg::CFG_PAD:      cfg_d.pad_before    = cfg_data_i[23:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= iaw_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && !q_full;

  iaw_front #(
    .DIM_WIDTH  (DIM_WIDTH),
    .KERN_WIDTH (KERN_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .restart_i (restart_i),
    .chan_o    (f_chan),
    .d_o       (f_d),
    .h_o       (f_h),
    .w_o       (f_w),
    .flags_o   (f_flags),
    .col_o     (f_col)
  );

  assign q_wdata = {image_base_i, f_col, f_flags, f_chan, f_d, f_h, f_w};
  assign {b_base, b_col, b_flags, b_chan, b_d, b_h, b_w} = q_rdata;

  iaw_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  logic b_ready;
  assign q_pop = q_valid && b_ready;

  iaw_back #(
    .DIM_WIDTH  (DIM_WIDTH),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (q_valid),
    .in_ready_o  (b_ready),
    .chan_i      (b_chan),
    .d_i         (b_d),
    .h_i         (b_h),
    .w_i         (b_w),
    .flags_i     (b_flags),
    .col_i       (b_col),
    .base_i      (b_base),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .src_addr_o  (src_addr_o),
    .pad_o       (pad_o),
    .col_index_o (col_index_o),
    .last_o      (last_o)
  );

endmodule

### hdl/iaw_fifo.sv
// Small register queue between the walk front end and the address back end.
// Generic payload vector; no package dependency.
module iaw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### hdl/iaw_front.sv
// Walk front end: holds the loop counters, turns them into input positions
// and classifies each element as padding or not. Uses iaw_pkg.
module iaw_front #(
  parameter int DIM_WIDTH  = 16,
  parameter int KERN_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iaw_pkg::iaw_cfg_t     cfg_i,
  input  logic                  accept_i,
  input  logic                  restart_i,
  output logic [15:0]           chan_o,
  output logic [DIM_WIDTH-1:0]  d_o,
  output logic [DIM_WIDTH-1:0]  h_o,
  output logic [DIM_WIDTH-1:0]  w_o,
  output iaw_pkg::iaw_flags_t   flags_o,
  output logic [31:0]           col_o
);

  localparam int DW     = DIM_WIDTH;
  localparam int KW     = KERN_WIDTH;
  localparam int PROD_W = (2 * KW > DW + KW) ? 2 * KW : DW + KW;
  localparam int PW     = PROD_W + 2;

  logic [15:0]   chan_q, chan_d, e_c, ext_c;
  logic [KW-1:0] kd_q, kd_d, kh_q, kh_d, kw_q, kw_d;
  logic [KW-1:0] e_kd, e_kh, e_kw, ext_kd, ext_kh, ext_kw;
  logic [DW-1:0] od_q, od_d, oh_q, oh_d, ow_q, ow_d;
  logic [DW-1:0] e_od, e_oh, e_ow, ext_od, ext_oh, ext_ow;
  logic [31:0]   col_q, col_d, e_col;

  logic [KW-1:0] k_d, k_h, k_w, dil_d, dil_h, dil_w, str_d, str_h, str_w;
  logic [KW-1:0] pb_d, pb_h, pb_w;
  logic [DW-1:0] o_d, o_h, o_w, n_d, n_h, n_w;
  logic [PW-1:0] pos_d, pos_h, pos_w;
  logic          pad_d, pad_h, pad_w;

  logic wrap_c, wrap_kd, wrap_kh, wrap_kw, wrap_od, wrap_oh, wrap_ow;
  logic cy_c, cy_kd, cy_kh, cy_kw, cy_od, cy_oh, cy_out, last;

  assign k_d   = cfg_i.kernel_size[2*KW +: KW];
  assign k_h   = cfg_i.kernel_size[KW +: KW];
  assign k_w   = cfg_i.kernel_size[0 +: KW];
  assign dil_d = cfg_i.dilation_size[2*KW +: KW];
  assign dil_h = cfg_i.dilation_size[KW +: KW];
  assign dil_w = cfg_i.dilation_size[0 +: KW];
  assign str_d = cfg_i.stride_size[2*KW +: KW];
  assign str_h = cfg_i.stride_size[KW +: KW];
  assign str_w = cfg_i.stride_size[0 +: KW];
  assign pb_d  = cfg_i.pad_before[2*KW +: KW];
  assign pb_h  = cfg_i.pad_before[KW +: KW];
  assign pb_w  = cfg_i.pad_before[0 +: KW];
  assign o_d   = cfg_i.out_size[2*DW +: DW];
  assign o_h   = cfg_i.out_size[DW +: DW];
  assign o_w   = cfg_i.out_size[0 +: DW];
  assign n_d   = cfg_i.in_size[2*DW +: DW];
  assign n_h   = cfg_i.in_size[DW +: DW];
  assign n_w   = cfg_i.in_size[0 +: DW];

  assign ext_c  = (cfg_i.channels == '0) ? 16'd1 : cfg_i.channels;
  assign ext_kd = (k_d == '0) ? KW'(1) : k_d;
  assign ext_kh = (k_h == '0) ? KW'(1) : k_h;
  assign ext_kw = (k_w == '0) ? KW'(1) : k_w;
  assign ext_od = (o_d == '0) ? DW'(1) : o_d;
  assign ext_oh = (o_h == '0) ? DW'(1) : o_h;
  assign ext_ow = (o_w == '0) ? DW'(1) : o_w;

  // restart clears the walk before this element is taken
  assign e_c   = restart_i ? '0 : chan_q;
  assign e_kd  = restart_i ? '0 : kd_q;
  assign e_kh  = restart_i ? '0 : kh_q;
  assign e_kw  = restart_i ? '0 : kw_q;
  assign e_od  = restart_i ? '0 : od_q;
  assign e_oh  = restart_i ? '0 : oh_q;
  assign e_ow  = restart_i ? '0 : ow_q;
  assign e_col = restart_i ? '0 : col_q;

  assign pos_d = PW'(e_kd) * PW'(dil_d) + PW'(e_od) * PW'(str_d) - PW'(pb_d);
  assign pos_h = PW'(e_kh) * PW'(dil_h) + PW'(e_oh) * PW'(str_h) - PW'(pb_h);
  assign pos_w = PW'(e_kw) * PW'(dil_w) + PW'(e_ow) * PW'(str_w) - PW'(pb_w);

  assign pad_d = pos_d[PW-1] || (pos_d[PW-2:0] >= (PW-1)'(n_d));
  assign pad_h = pos_h[PW-1] || (pos_h[PW-2:0] >= (PW-1)'(n_h));
  assign pad_w = pos_w[PW-1] || (pos_w[PW-2:0] >= (PW-1)'(n_w));

  assign wrap_c  = ({1'b0, e_c} + 17'd1) >= {1'b0, ext_c};
  assign wrap_kd = ({1'b0, e_kd} + (KW+1)'(1)) >= {1'b0, ext_kd};
  assign wrap_kh = ({1'b0, e_kh} + (KW+1)'(1)) >= {1'b0, ext_kh};
  assign wrap_kw = ({1'b0, e_kw} + (KW+1)'(1)) >= {1'b0, ext_kw};
  assign wrap_od = ({1'b0, e_od} + (DW+1)'(1)) >= {1'b0, ext_od};
  assign wrap_oh = ({1'b0, e_oh} + (DW+1)'(1)) >= {1'b0, ext_oh};
  assign wrap_ow = ({1'b0, e_ow} + (DW+1)'(1)) >= {1'b0, ext_ow};

  // carry chain: output axes innermost, then kernel and channel in layout order
  always_comb begin
    cy_oh  = wrap_ow;
    cy_od  = cy_oh && wrap_oh;
    cy_out = cy_od && wrap_od;
    if (cfg_i.layout) begin
      cy_c  = cy_out;
      cy_kw = cy_c && wrap_c;
      cy_kh = cy_kw && wrap_kw;
      cy_kd = cy_kh && wrap_kh;
      last  = cy_kd && wrap_kd;
    end else begin
      cy_kw = cy_out;
      cy_kh = cy_kw && wrap_kw;
      cy_kd = cy_kh && wrap_kh;
      cy_c  = cy_kd && wrap_kd;
      last  = cy_c && wrap_c;
    end
  end

  always_comb begin
    ow_d   = wrap_ow ? '0 : e_ow + 1'b1;
    oh_d   = cy_oh ? (wrap_oh ? '0 : e_oh + 1'b1) : e_oh;
    od_d   = cy_od ? (wrap_od ? '0 : e_od + 1'b1) : e_od;
    kw_d   = cy_kw ? (wrap_kw ? '0 : e_kw + 1'b1) : e_kw;
    kh_d   = cy_kh ? (wrap_kh ? '0 : e_kh + 1'b1) : e_kh;
    kd_d   = cy_kd ? (wrap_kd ? '0 : e_kd + 1'b1) : e_kd;
    chan_d = cy_c ? (wrap_c ? '0 : e_c + 1'b1) : e_c;
    col_d  = last ? '0 : e_col + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      kd_q   <= '0;
      kh_q   <= '0;
      kw_q   <= '0;
      od_q   <= '0;
      oh_q   <= '0;
      ow_q   <= '0;
      col_q  <= '0;
    end else if (accept_i) begin
      chan_q <= chan_d;
      kd_q   <= kd_d;
      kh_q   <= kh_d;
      kw_q   <= kw_d;
      od_q   <= od_d;
      oh_q   <= oh_d;
      ow_q   <= ow_d;
      col_q  <= col_d;
    end
  end

  assign chan_o        = e_c;
  assign d_o           = pos_d[DW-1:0];
  assign h_o           = pos_h[DW-1:0];
  assign w_o           = pos_w[DW-1:0];
  assign flags_o.pad   = pad_d || pad_h || pad_w;
  assign flags_o.last  = last;
  assign col_o         = e_col;

endmodule

### hdl/iaw_back.sv
// Address back end: five-stage pipeline that folds the input position into
// an element offset and adds the image base. Uses iaw_pkg.
module iaw_back #(
  parameter int DIM_WIDTH  = 16,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iaw_pkg::iaw_cfg_t     cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [15:0]           chan_i,
  input  logic [DIM_WIDTH-1:0]  d_i,
  input  logic [DIM_WIDTH-1:0]  h_i,
  input  logic [DIM_WIDTH-1:0]  w_i,
  input  iaw_pkg::iaw_flags_t   flags_i,
  input  logic [31:0]           col_i,
  input  logic [31:0]           base_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           src_addr_o,
  output logic                  pad_o,
  output logic [31:0]           col_index_o,
  output logic                  last_o
);

  localparam int DW = DIM_WIDTH;
  localparam int AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;

  logic          en;
  logic [DW-1:0] sz_d, sz_h, sz_w;
  logic [AW-1:0] addr;

  logic          v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [AW-1:0] s1_dh_q, s1_cd_q, s2_dhw_q, s2_cdh_q, s3_sp_q, s3_cdhw_q;
  logic [AW-1:0] s4_cl_q, s4_cf_q;
  logic [DW-1:0] s1_h_q, s1_w_q, s2_w_q;
  logic [15:0]   s1_c_q, s2_c_q, s3_c_q, s4_c_q;
  logic [31:0]   s1_col_q, s2_col_q, s3_col_q, s4_col_q, s5_col_q;
  logic [31:0]   s1_base_q, s2_base_q, s3_base_q, s4_base_q;
  iaw_pkg::iaw_flags_t s1_fl_q, s2_fl_q, s3_fl_q, s4_fl_q, s5_fl_q;
  logic [31:0]   s5_src_q;

  assign sz_d = cfg_i.in_size[2*DW +: DW];
  assign sz_h = cfg_i.in_size[DW +: DW];
  assign sz_w = cfg_i.in_size[0 +: DW];

  // advance the whole pipe unless the output item is held
  assign en         = !v5_q || out_ready_i;
  assign in_ready_o = en;

  assign addr = (cfg_i.layout ? s4_cl_q + AW'(s4_c_q) : s4_cf_q) + AW'(s4_base_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dh_q   <= AW'(d_i) * AW'(sz_h);
      s1_cd_q   <= AW'(chan_i) * AW'(sz_d);
      s1_h_q    <= h_i;
      s1_w_q    <= w_i;
      s1_c_q    <= chan_i;
      s1_fl_q   <= flags_i;
      s1_col_q  <= col_i;
      s1_base_q <= base_i;

      s2_dhw_q  <= (s1_dh_q + AW'(s1_h_q)) * AW'(sz_w);
      s2_cdh_q  <= s1_cd_q * AW'(sz_h);
      s2_w_q    <= s1_w_q;
      s2_c_q    <= s1_c_q;
      s2_fl_q   <= s1_fl_q;
      s2_col_q  <= s1_col_q;
      s2_base_q <= s1_base_q;

      s3_sp_q   <= s2_dhw_q + AW'(s2_w_q);
      s3_cdhw_q <= s2_cdh_q * AW'(sz_w);
      s3_c_q    <= s2_c_q;
      s3_fl_q   <= s2_fl_q;
      s3_col_q  <= s2_col_q;
      s3_base_q <= s2_base_q;

      s4_cl_q   <= s3_sp_q * AW'(cfg_i.channels);
      s4_cf_q   <= s3_cdhw_q + s3_sp_q;
      s4_c_q    <= s3_c_q;
      s4_fl_q   <= s3_fl_q;
      s4_col_q  <= s3_col_q;
      s4_base_q <= s3_base_q;

      s5_src_q  <= s4_fl_q.pad ? '0 : 32'(addr);
      s5_fl_q   <= s4_fl_q;
      s5_col_q  <= s4_col_q;
    end
  end

  assign out_valid_o = v5_q;
  assign src_addr_o  = s5_src_q;
  assign pad_o       = s5_fl_q.pad;
  assign col_index_o = s5_col_q;
  assign last_o      = s5_fl_q.last;

endmodule

### hdl/iaw_checker.sv
// Port-level checks for the im2col address walker, attached by bind.
// Depends on im2col_address_walker port names.
module iaw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] src_addr_o,
  input logic        pad_o,
  input logic [31:0] col_index_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable({src_addr_o, pad_o, col_index_o, last_o}))
    else $error("output item changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pad_o |-> src_addr_o == 32'd0)
    else $error("padding element carries a nonzero address");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input blocked without an output stall");

endmodule

bind im2col_address_walker iaw_checker u_iaw_checker (.*);

### bench/im2col_address_walker_tb.sv
// Self-checking bench for im2col_address_walker: a directed table, then random
// register settings and base addresses, checked against a behavioral walk model.
// Depends on iaw_pkg and the walker RTL.
`timescale 1ns / 1ps

module im2col_address_walker_tb;

  localparam int RANDOM_GOAL    = 1300;
  localparam int QUIET_TAIL     = 150;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RX_HOLD_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  typedef enum int {AX_OW, AX_OH, AX_OD, AX_CH, AX_KW, AX_KH, AX_KD} walk_axis_e;
  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    logic [31:0] src_addr;
    logic        pad;
    logic [31:0] col_index;
    logic        last;
  } walk_elem_t;

  typedef struct packed {
    row_kind_e                      kind;
    logic [iaw_pkg::CFG_IDX_W-1:0]  idx;
    logic [iaw_pkg::CFG_DATA_W-1:0] data;
    logic                           restart;
    logic [31:0]                    base;
    logic                           known;
    walk_elem_t                     want;
  } stim_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [iaw_pkg::CFG_IDX_W-1:0]  cfg_index_i = iaw_pkg::CFG_LAYOUT;
  logic [iaw_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic                           restart_i = 1'b0;
  logic [31:0]                    image_base_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [31:0]                    src_addr_o;
  logic                           pad_o;
  logic [31:0]                    col_index_o;
  logic                           last_o;

  iaw_pkg::iaw_cfg_t cfg_model = iaw_pkg::CFG_RESET;
  logic [15:0] walk_cnt [7];
  int unsigned walk_ext [7];
  logic [31:0] col_cnt = '0;

  walk_elem_t  expected_elems [$];
  stim_row_t   stim_rows [$];
  int unsigned fail_cnt = 0;
  int unsigned items_sent = 0;
  bit          idle_on = 1'b1;
  bit          rx_hold_req = 1'b0;

  im2col_address_walker i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .image_base_i (image_base_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .src_addr_o   (src_addr_o),
    .pad_o        (pad_o),
    .col_index_o  (col_index_o),
    .last_o       (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    foreach (walk_cnt[i]) walk_cnt[i] = '0;
  end

  function automatic int unsigned walk_span(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic longint axis_pos(input int a, input int unsigned k, input int unsigned o);
    longint dil, str, pb;
    dil = cfg_model.dilation_size[8*a +: 8];
    str = cfg_model.stride_size[8*a +: 8];
    pb  = cfg_model.pad_before[8*a +: 8];
    return longint'(k) * dil - pb + longint'(o) * str;
  endfunction

  function automatic void step_axis(input walk_axis_e ax, inout bit carry);
    if (carry) begin
      if (32'(walk_cnt[ax]) + 32'd1 >= walk_ext[ax]) begin
        walk_cnt[ax] = '0;
      end else begin
        walk_cnt[ax] = walk_cnt[ax] + 16'd1;
        carry = 1'b0;
      end
    end
  endfunction

  function automatic walk_elem_t next_column_elem(input logic restart, input logic [31:0] base);
    walk_elem_t e;
    longint pd, ph, pw, nd, nh, nw, sp, off;
    bit carry;
    walk_ext[AX_CH] = walk_span(cfg_model.channels);
    walk_ext[AX_KD] = walk_span(cfg_model.kernel_size[23:16]);
    walk_ext[AX_KH] = walk_span(cfg_model.kernel_size[15:8]);
    walk_ext[AX_KW] = walk_span(cfg_model.kernel_size[7:0]);
    walk_ext[AX_OD] = walk_span(cfg_model.out_size[47:32]);
    walk_ext[AX_OH] = walk_span(cfg_model.out_size[31:16]);
    walk_ext[AX_OW] = walk_span(cfg_model.out_size[15:0]);
    nd = cfg_model.in_size[47:32];
    nh = cfg_model.in_size[31:16];
    nw = cfg_model.in_size[15:0];
    if (restart) begin
      foreach (walk_cnt[i]) walk_cnt[i] = '0;
      col_cnt = '0;
    end
    pd = axis_pos(2, walk_cnt[AX_KD], walk_cnt[AX_OD]);
    ph = axis_pos(1, walk_cnt[AX_KH], walk_cnt[AX_OH]);
    pw = axis_pos(0, walk_cnt[AX_KW], walk_cnt[AX_OW]);
    e.pad = pd < 0 || pd >= nd || ph < 0 || ph >= nh || pw < 0 || pw >= nw;
    e.src_addr = '0;
    if (!e.pad) begin
      sp = (pd * nh + ph) * nw + pw;
      if (cfg_model.layout) off = sp * longint'(cfg_model.channels) + longint'(walk_cnt[AX_CH]);
      else off = longint'(walk_cnt[AX_CH]) * nd * nh * nw + sp;
      e.src_addr = 32'(longint'(base) + off);
    end
    e.col_index = col_cnt;
    carry = 1'b1;
    step_axis(AX_OW, carry);
    step_axis(AX_OH, carry);
    step_axis(AX_OD, carry);
    if (cfg_model.layout) begin
      step_axis(AX_CH, carry);
      step_axis(AX_KW, carry);
      step_axis(AX_KH, carry);
      step_axis(AX_KD, carry);
    end else begin
      step_axis(AX_KW, carry);
      step_axis(AX_KH, carry);
      step_axis(AX_KD, carry);
      step_axis(AX_CH, carry);
    end
    e.last = carry;
    col_cnt = carry ? 32'd0 : col_cnt + 32'd1;
    return e;
  endfunction

  function automatic logic [7:0] pick_k(input int unsigned hi);
    case ($urandom_range(0, 15))
      0: return 8'hFF;
      1: return 8'h00;
      2: return 8'($urandom());
      default: return 8'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic logic [15:0] pick_d(input int unsigned hi);
    case ($urandom_range(0, 15))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom_range(0, 300));
      default: return 16'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic logic [iaw_pkg::CFG_DATA_W-1:0] noisy(
      input int w, input logic [iaw_pkg::CFG_DATA_W-1:0] v);
    logic [iaw_pkg::CFG_DATA_W-1:0] junk;
    junk = iaw_pkg::CFG_DATA_W'({$urandom(), $urandom()});
    if ($urandom_range(0, 1) == 0) junk = '0;
    return (junk << w) | v;
  endfunction

  function automatic void add_row(input stim_row_t r);
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  function automatic void add_cfg(input logic [iaw_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [iaw_pkg::CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    add_row(r);
  endfunction

  function automatic void add_item(input logic restart, input logic [31:0] base);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.restart = restart;
    r.base = base;
    add_row(r);
  endfunction

  function automatic void add_known(input logic restart, input logic [31:0] base,
                                    input logic [31:0] addr, input logic pad,
                                    input logic last);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.restart = restart;
    r.base = base;
    r.known = 1'b1;
    r.want = '{src_addr: addr, pad: pad, col_index: 32'd0, last: last};
    add_row(r);
  endfunction

  task automatic write_reg(input logic [iaw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [iaw_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      iaw_pkg::CFG_LAYOUT:   cfg_model.layout        = data[0];
      iaw_pkg::CFG_CHANNELS: cfg_model.channels      = data[15:0];
      iaw_pkg::CFG_KERNEL:   cfg_model.kernel_size   = data[23:0];
      iaw_pkg::CFG_IN_SIZE:  cfg_model.in_size       = data[47:0];
      iaw_pkg::CFG_OUT_SIZE: cfg_model.out_size      = data[47:0];
      iaw_pkg::CFG_STRIDE:   cfg_model.stride_size   = data[23:0];
      iaw_pkg::CFG_DILATION: cfg_model.dilation_size = data[23:0];
      iaw_pkg::CFG_PAD:      cfg_model.pad_before    = data[23:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_item(input logic restart, input logic [31:0] base,
                           input logic known, input walk_elem_t known_elem);
    walk_elem_t e;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    restart_i    <= restart;
    image_base_i <= base;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    e = next_column_elem(restart, base);
    expected_elems.insert(expected_elems.size(), known ? known_elem : e);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (expected_elems.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    walk_elem_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_elems.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT)
          $display("unexpected item: addr %h pad %b col %0d last %b",
                   src_addr_o, pad_o, col_index_o, last_o);
      end else begin
        want = expected_elems.pop_front();
        if (src_addr_o !== want.src_addr || pad_o !== want.pad ||
            col_index_o !== want.col_index || last_o !== want.last) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT)
            $display("mismatch: want addr %h pad %b col %0d last %b, got addr %h pad %b col %0d last %b",
                     want.src_addr, want.pad, want.col_index, want.last,
                     src_addr_o, pad_o, col_index_o, last_o);
        end
      end
    end
  end

  initial begin : receiver
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    bit cfg_open, walk_open;
    int phase_no, phase_len;
    cfg_open = 1'b0;
    walk_open = 1'b0;

    add_known(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
    add_known(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    add_known(1'b0, 32'h5555_AAAA, 32'h5555_AAAA, 1'b0, 1'b1);
    add_cfg(iaw_pkg::CFG_CHANNELS, 48'd2);
    add_cfg(iaw_pkg::CFG_KERNEL, 48'h01_02_02);
    add_cfg(iaw_pkg::CFG_IN_SIZE, 48'h0002_0003_0003);
    add_cfg(iaw_pkg::CFG_OUT_SIZE, 48'h0001_0002_0002);
    add_cfg(iaw_pkg::CFG_STRIDE, 48'h01_02_01);
    add_cfg(iaw_pkg::CFG_DILATION, 48'h01_01_02);
    add_cfg(iaw_pkg::CFG_PAD, 48'h00_01_01);
    add_item(1'b1, 32'h0000_1000);
    repeat (5) add_item(1'b0, $urandom());
    add_cfg(iaw_pkg::CFG_LAYOUT, 48'd1);
    repeat (4) add_item(1'b0, $urandom());
    // shrink the output while counters sit past the new extent
    add_cfg(iaw_pkg::CFG_OUT_SIZE, 48'h0001_0001_0001);
    add_item(1'b0, $urandom());
    add_cfg(iaw_pkg::CFG_CHANNELS, 48'd0);
    add_cfg(iaw_pkg::CFG_KERNEL, 48'd0);
    add_cfg(iaw_pkg::CFG_OUT_SIZE, 48'd0);
    add_cfg(iaw_pkg::CFG_IN_SIZE, 48'd0);
    add_known(1'b1, $urandom(), 32'd0, 1'b1, 1'b1);
    add_known(1'b0, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1);
    add_cfg(iaw_pkg::CFG_LAYOUT, 48'd0);
    add_cfg(iaw_pkg::CFG_KERNEL, 48'h01_02_02);
    add_cfg(iaw_pkg::CFG_IN_SIZE, 48'h0001_0001_0001);
    add_cfg(iaw_pkg::CFG_OUT_SIZE, 48'h0001_0003_0003);
    add_cfg(iaw_pkg::CFG_STRIDE, 48'd0);
    add_cfg(iaw_pkg::CFG_DILATION, 48'd0);
    add_cfg(iaw_pkg::CFG_PAD, 48'd0);
    add_item(1'b1, $urandom());
    repeat (3) add_item(1'b0, $urandom());
    add_cfg(iaw_pkg::CFG_LAYOUT, 48'd1);
    add_cfg(iaw_pkg::CFG_CHANNELS, 48'hFFFF);
    add_cfg(iaw_pkg::CFG_KERNEL, 48'hFF_FF_FF);
    add_cfg(iaw_pkg::CFG_IN_SIZE, 48'hFFFF_FFFF_FFFF);
    add_cfg(iaw_pkg::CFG_OUT_SIZE, 48'hFFFF_FFFF_FFFF);
    add_cfg(iaw_pkg::CFG_STRIDE, 48'hFF_FF_FF);
    add_cfg(iaw_pkg::CFG_DILATION, 48'hFF_FF_FF);
    add_item(1'b1, 32'hFFFF_FFFF);
    add_item(1'b0, 32'h0000_0000);
    add_item(1'b0, 32'hFFFF_FFFF);
    add_cfg(iaw_pkg::CFG_PAD, 48'hFF_FF_FF);
    add_item(1'b0, $urandom());

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_CFG) begin
        if (walk_open) quiesce();
        write_reg(stim_rows[r].idx, stim_rows[r].data);
        cfg_open = 1'b1;
        walk_open = 1'b0;
      end else begin
        if (cfg_open) cfg_valid_i <= 1'b0;
        cfg_open = 1'b0;
        send_item(stim_rows[r].restart, stim_rows[r].base, stim_rows[r].known,
                  stim_rows[r].want);
        walk_open = 1'b1;
      end
    end

    phase_no = 0;
    while (items_sent < RANDOM_GOAL) begin
      phase_len = $urandom_range(40, 120);
      quiesce();
      if ($urandom_range(0, 3) != 0)
        write_reg(iaw_pkg::CFG_LAYOUT, noisy(1, 48'($urandom_range(0, 1))));
      if ($urandom_range(0, 3) != 0)
        write_reg(iaw_pkg::CFG_CHANNELS, noisy(16, pick_d(2)));
      if ($urandom_range(0, 3) != 0)
        write_reg(iaw_pkg::CFG_KERNEL, noisy(24, {pick_k(1), pick_k(2), pick_k(2)}));
      if ($urandom_range(0, 3) != 0)
        write_reg(iaw_pkg::CFG_IN_SIZE, noisy(48, {pick_d(4), pick_d(5), pick_d(5)}));
      if ($urandom_range(0, 3) != 0)
        write_reg(iaw_pkg::CFG_OUT_SIZE, noisy(48, {pick_d(1), pick_d(2), pick_d(3)}));
      if ($urandom_range(0, 3) != 0)
        write_reg(iaw_pkg::CFG_STRIDE, noisy(24, {pick_k(2), pick_k(2), pick_k(2)}));
      if ($urandom_range(0, 3) != 0)
        write_reg(iaw_pkg::CFG_DILATION, noisy(24, {pick_k(2), pick_k(2), pick_k(2)}));
      if ($urandom_range(0, 3) != 0)
        write_reg(iaw_pkg::CFG_PAD, noisy(24, {pick_k(2), pick_k(2), pick_k(2)}));
      cfg_valid_i <= 1'b0;
      idle_on = (RANDOM_GOAL - items_sent > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      // back up the output so the queue fills and the input stalls
      if (phase_no == 2) begin
        idle_on = 1'b0;
        rx_hold_req = 1'b1;
      end
      for (int i = 0; i < phase_len; i++) begin
        if (phase_no == 4 && i == phase_len / 2) quiesce();
        send_item($urandom_range(0, 31) == 0, $urandom(), 1'b0, '0);
      end
      phase_no++;
    end

    quiesce();
    if (expected_elems.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
